// ===== hw/rtl/acd_pkg.sv =====
// Shared types, register codes, S-box tables and round helpers for the AES-256 CBC decryptor.
`timescale 1ns / 1ps
package acd_pkg;

  localparam int NUM_ROUNDS = 14;
  localparam int NUM_WORDS  = 60;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IV_HIGH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IV_LOW     = 3'd5;

  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [63:0]          data;
  } acd_cfg_wr_t;

  typedef struct packed {
    logic [127:0] cipher;
    logic [127:0] chain;
  } acd_item_t;

  typedef logic [NUM_WORDS-1:0][31:0] acd_rk_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // byte 0 of the state sits in the top bits
  function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[127 - 8 * (r + 4 * c) -: 8] = INV_SBOX[s[127 - 8 * (r + 4 * ((c + 4 - r) & 3)) -: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [31:0] inv_mix_col(input logic [31:0] col);
    logic [7:0] a [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    logic [7:0] x2, x4, x8;
    for (int i = 0; i < 4; i++) begin
      a[i]  = col[31 - 8 * i -: 8];
      x2    = xtime(a[i]);
      x4    = xtime(x2);
      x8    = xtime(x4);
      m9[i] = x8 ^ a[i];
      mb[i] = x8 ^ x2 ^ a[i];
      md[i] = x8 ^ x4 ^ a[i];
      me[i] = x8 ^ x4 ^ x2;
    end
    return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
            m9[0] ^ me[1] ^ mb[2] ^ md[3],
            md[0] ^ m9[1] ^ me[2] ^ mb[3],
            mb[0] ^ md[1] ^ m9[2] ^ me[3]};
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    return {inv_mix_col(s[127:96]), inv_mix_col(s[95:64]),
            inv_mix_col(s[63:32]), inv_mix_col(s[31:0])};
  endfunction

  function automatic logic [127:0] round_key(input acd_rk_t rk, input int unsigned rnd);
    return {rk[4 * rnd], rk[4 * rnd + 1], rk[4 * rnd + 2], rk[4 * rnd + 3]};
  endfunction

endpackage

// ===== hw/rtl/acd_ifs.sv =====
// Channel interfaces: ciphertext in, plaintext out, register writes.
`timescale 1ns / 1ps
interface acd_cipher_if;
  logic        valid;
  logic        ready;
  logic [63:0] cipher_high;
  logic [63:0] cipher_low;
  logic        first_block;
  modport source (output valid, cipher_high, cipher_low, first_block, input ready);
  modport sink (input valid, cipher_high, cipher_low, first_block, output ready);
endinterface

interface acd_plain_if;
  logic        valid;
  logic        ready;
  logic [63:0] plain_high;
  logic [63:0] plain_low;
  modport source (output valid, plain_high, plain_low, input ready);
  modport sink (input valid, plain_high, plain_low, output ready);
endinterface

interface acd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/acd_keyexp.sv =====
// Key registers and sequential AES-256 key expansion into a 60-word shift line.
`timescale 1ns / 1ps
module acd_keyexp
  import acd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  acd_cfg_wr_t cfg_wr,
  output acd_rk_t     rk,
  output logic        busy
);

  localparam int STEPS = NUM_WORDS - 8;

  logic [3:0][63:0] key_regs;
  logic             load_pend;
  logic [5:0]       step;
  logic [7:0]       rcon;
  logic [31:0]      sub_in;
  logic [31:0]      sub_out;
  logic [31:0]      new_word;
  logic             running;

  assign running = (step != 6'(STEPS));
  assign busy    = load_pend || running;

  // rk[59] holds w[i-1], rk[52] holds w[i-8]
  always_comb begin
    sub_in  = (step[2:0] == 3'd0) ? {rk[NUM_WORDS-1][23:0], rk[NUM_WORDS-1][31:24]}
                                  : rk[NUM_WORDS-1];
    sub_out = sub_word(sub_in);
    unique case (step[2:0])
      3'd0:    new_word = rk[NUM_WORDS-8] ^ sub_out ^ {rcon, 24'h0};
      3'd4:    new_word = rk[NUM_WORDS-8] ^ sub_out;
      default: new_word = rk[NUM_WORDS-8] ^ rk[NUM_WORDS-1];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_regs  <= '0;
      load_pend <= 1'b1;
      step      <= 6'(STEPS);
      rcon      <= 8'h01;
    end else begin
      if (load_pend) begin
        for (int j = 0; j < 4; j++) begin
          rk[NUM_WORDS-8+2*j]   <= key_regs[j][63:32];
          rk[NUM_WORDS-8+2*j+1] <= key_regs[j][31:0];
        end
        step      <= '0;
        rcon      <= 8'h01;
        load_pend <= 1'b0;
      end else if (running) begin
        for (int j = 0; j < NUM_WORDS - 1; j++) begin
          rk[j] <= rk[j+1];
        end
        rk[NUM_WORDS-1] <= new_word;
        step            <= step + 6'd1;
        if (step[2:0] == 3'd0) begin
          rcon <= xtime(rcon);
        end
      end
      if (cfg_wr.valid && (cfg_wr.index == REG_KEY_WORD_0 || cfg_wr.index == REG_KEY_WORD_1 ||
                           cfg_wr.index == REG_KEY_WORD_2 || cfg_wr.index == REG_KEY_WORD_3)) begin
        key_regs[cfg_wr.index[1:0]] <= cfg_wr.data;
        load_pend                   <= 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/acd_front.sv =====
// Front end: accepts ciphertext, picks the chain value, holds IV and previous block.
`timescale 1ns / 1ps
module acd_front
  import acd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  acd_cfg_wr_t cfg_wr,
  input  logic        in_valid,
  input  logic [63:0] cipher_high,
  input  logic [63:0] cipher_low,
  input  logic        first_block,
  input  logic        accept,
  output logic        push,
  output acd_item_t   push_item
);

  logic [127:0] iv;
  logic [127:0] prev_block;

  assign push             = in_valid && accept;
  assign push_item.cipher = {cipher_high, cipher_low};
  assign push_item.chain  = first_block ? iv : prev_block;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv         <= '0;
      prev_block <= '0;
    end else begin
      if (push) begin
        prev_block <= {cipher_high, cipher_low};
      end
      if (cfg_wr.valid && cfg_wr.index == REG_IV_HIGH) begin
        iv[127:64] <= cfg_wr.data;
      end
      if (cfg_wr.valid && cfg_wr.index == REG_IV_LOW) begin
        iv[63:0] <= cfg_wr.data;
      end
    end
  end

endmodule

// ===== hw/rtl/acd_fifo.sv =====
// Two-entry queue between the front end and the round pipeline.
`timescale 1ns / 1ps
module acd_fifo
  import acd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  acd_item_t push_item,
  input  logic      pop,
  output logic      empty,
  output logic      full,
  output acd_item_t head
);

  acd_item_t  mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== hw/rtl/acd_back.sv =====
// Back end: 15-stage inverse-round pipeline with chain XOR at the last stage.
`timescale 1ns / 1ps
module acd_back
  import acd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  acd_rk_t      rk,
  input  logic         src_valid,
  input  acd_item_t    src_item,
  output logic         src_pop,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [127:0] out_data
);

  localparam int STAGES = NUM_ROUNDS + 1;

  logic [127:0]      st  [STAGES];
  logic [127:0]      chn [STAGES-1];
  logic [STAGES-1:0] vld;
  logic              advance;

  assign advance   = !vld[STAGES-1] || out_ready;
  assign src_pop   = advance && src_valid;
  assign out_valid = vld[STAGES-1];
  assign out_data  = st[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[STAGES-2:0], src_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      st[0]  <= src_item.cipher ^ round_key(rk, NUM_ROUNDS);
      chn[0] <= src_item.chain;
      for (int s = 1; s < STAGES - 1; s++) begin
        st[s]  <= inv_mix(inv_shift_sub(st[s-1]) ^ round_key(rk, NUM_ROUNDS - s));
        chn[s] <= chn[s-1];
      end
      st[STAGES-1]  <= inv_shift_sub(st[STAGES-2]) ^ round_key(rk, 0) ^ chn[STAGES-2];
    end
  end

endmodule

// ===== hw/rtl/aes256_cbc_decrypt_unit.sv =====
// AES-256 CBC decryptor: one ciphertext block per cycle through a 15-stage round pipeline
// while the output is ready and the key schedule is idle. Each accepted block is written
// into the two-entry queue, then crosses the 15 round stages.
// Throughput: one block per cycle without output or key stalls, set by the fully staged
// inverse rounds. Reset (rst, synchronous): key, IV and chain clear to zero; the key
// schedule then expands, and again after any key write, with input ready held low.
`timescale 1ns / 1ps
module aes256_cbc_decrypt_unit
  import acd_pkg::*;
(
  input logic           clk,
  input logic           rst,
  acd_cipher_if.sink    blk_cipher,
  acd_plain_if.source   blk_plain,
  acd_cfg_if.sink       cfg
);

  acd_cfg_wr_t  cfg_wr;
  acd_rk_t      rk;
  logic         key_busy;
  logic         push;
  acd_item_t    push_item;
  logic         pop;
  logic         q_empty;
  logic         q_full;
  acd_item_t    q_head;
  logic [127:0] out_data;

  assign cfg.ready    = 1'b1;
  assign cfg_wr.valid = cfg.valid;
  assign cfg_wr.index = cfg.index;
  assign cfg_wr.data  = cfg.data;

  assign blk_cipher.ready = !q_full && !key_busy;

  acd_keyexp u_keyexp (
    .clk    (clk),
    .rst    (rst),
    .cfg_wr (cfg_wr),
    .rk     (rk),
    .busy   (key_busy)
  );

  acd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr      (cfg_wr),
    .in_valid    (blk_cipher.valid),
    .cipher_high (blk_cipher.cipher_high),
    .cipher_low  (blk_cipher.cipher_low),
    .first_block (blk_cipher.first_block),
    .accept      (blk_cipher.ready),
    .push        (push),
    .push_item   (push_item)
  );

  acd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .empty     (q_empty),
    .full      (q_full),
    .head      (q_head)
  );

  acd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rk        (rk),
    .src_valid (!q_empty),
    .src_item  (q_head),
    .src_pop   (pop),
    .out_valid (blk_plain.valid),
    .out_ready (blk_plain.ready),
    .out_data  (out_data)
  );

  assign blk_plain.plain_high = out_data[127:64];
  assign blk_plain.plain_low  = out_data[63:0];

endmodule
